FILE: rtl/gbo_pkg.sv
package gbo_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int GYRO_W     = 10;
    localparam int WANT_W     = 12;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int APPLY_W    = 7;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 40;

    // internal arithmetic widths
    localparam int DIFF_W        = 13;
    localparam int ERR3_W        = 15;
    localparam int DIV_W         = 10;
    localparam int DIV_CYCLES    = DIV_W / 2;
    localparam int CNT_W         = $clog2(DIV_CYCLES);
    localparam int KNEE_MAG_W    = 13;
    localparam int KNEE_Q_W      = 4;
    localparam int KNEE_OUT_W    = 12;
    localparam int ANKLE_MAG_W   = 6;
    localparam int ANKLE_OUT_W   = 8;
    localparam int AROLL_MAG_W   = 6;
    localparam int AROLL_OUT_W   = 7;
    localparam int HROLL_MAG_W   = 5;
    localparam int HROLL_OUT_W   = 6;

    // fixed divisors
    localparam logic [DIV_W-1:0] KNEE_DIV  = 10'd70;
    localparam logic [DIV_W-1:0] ANKLE_DIV = 10'd25;
    localparam logic [DIV_W-1:0] AROLL_DIV = 10'd30;
    localparam logic [DIV_W-1:0] HROLL_DIV = 10'd52;

    localparam logic [KNEE_OUT_W-1:0] KNEE_POS_MAX = 12'd2047;
    localparam logic [KNEE_OUT_W-1:0] KNEE_NEG_MAX = 12'd2048;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] PERIOD_RST     = 10'd30;
    localparam logic [CFG_DATA_W-1:0] FB_LIMIT_RST   = 10'd250;
    localparam logic [CFG_DATA_W-1:0] SIDE_LIMIT_RST = 10'd300;
    localparam logic [CFG_DATA_W-1:0] DEADBAND_RST   = 10'd15;
    localparam logic [APPLY_W-1:0]    APPLY_RST      = 7'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD,
        REG_FB_LIMIT,
        REG_SIDE_LIMIT,
        REG_DEADBAND,
        REG_APPLY_LIMIT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_CLAMP,
        S_DIV_KNEE,
        S_DIV_ANKLE,
        S_DIV_AROLL,
        S_DIV_HROLL,
        S_KNEE_ADJ,
        S_KNEE_DIV,
        S_ANKLE_ADJ,
        S_ANKLE_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] period;
        logic [CFG_DATA_W-1:0] fb_limit;
        logic [CFG_DATA_W-1:0] side_limit;
        logic [CFG_DATA_W-1:0] deadband;
        logic [APPLY_W-1:0]    apply_limit;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic [GYRO_W-1:0]        gyro_front_back;
        logic [GYRO_W-1:0]        gyro_side;
        logic signed [WANT_W-1:0] wanted_front_back;
        logic signed [WANT_W-1:0] wanted_side;
        logic [POS_W-1:0]         knee_position;
        logic [POS_W-1:0]         knee_goal;
        logic [POS_W-1:0]         ankle_position;
        logic [POS_W-1:0]         ankle_goal;
    } item_t;

    typedef struct packed {
        logic signed [KNEE_OUT_W-1:0]  knee_offset;
        logic                          knee_write;
        logic signed [ANKLE_OUT_W-1:0] ankle_pitch_offset;
        logic                          ankle_pitch_write;
        logic signed [HROLL_OUT_W-1:0] hip_roll_offset;
        logic signed [AROLL_OUT_W-1:0] ankle_roll_offset;
    } res_t;

endpackage

FILE: rtl/gyro_balance_offset_step_top.sv
// an item that triggers an update gives its result on m_axis after four fixed divisions,
// which always run, plus the knee and ankle deviation divisions when they are taken;
// every division runs on the shared radix-4 divider. an item inside the update period
// is dropped. a new item is accepted only once the last one is dropped or its result
// has passed to the output register.
// reset: asynchronous, clears state, last update time to 0 and registers to defaults
module gyro_balance_offset_step_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // time_ms, gyro_front_back, gyro_side, wanted_front_back, wanted_side,
    // knee_position, knee_goal, ankle_position, ankle_goal, zero pad
    input  logic [gbo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // knee_offset, knee_write, ankle_pitch_offset, ankle_pitch_write,
    // hip_roll_offset, ankle_roll_offset, zero pad
    output logic [gbo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gbo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbo_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gbo_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    item_t item;
    res_t  res;
    res_t  out_reg;
    logic  out_valid_reg, out_valid_next;
    logic  res_valid;
    logic  res_ready;

    assign item.time_ms           = s_axis_tdata[31:0];
    assign item.gyro_front_back   = s_axis_tdata[41:32];
    assign item.gyro_side         = s_axis_tdata[51:42];
    assign item.wanted_front_back = s_axis_tdata[63:52];
    assign item.wanted_side       = s_axis_tdata[75:64];
    assign item.knee_position     = s_axis_tdata[85:76];
    assign item.knee_goal         = s_axis_tdata[95:86];
    assign item.ankle_position    = s_axis_tdata[105:96];
    assign item.ankle_goal        = s_axis_tdata[115:106];

    gbo_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item       (item),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD:      cfg_next.period      = cfg_data;
                REG_FB_LIMIT:    cfg_next.fb_limit    = cfg_data;
                REG_SIDE_LIMIT:  cfg_next.side_limit  = cfg_data;
                REG_DEADBAND:    cfg_next.deadband    = cfg_data;
                REG_APPLY_LIMIT: cfg_next.apply_limit = cfg_data[APPLY_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    // output register keeps the core free while a result waits downstream
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period      <= PERIOD_RST;
            cfg_reg.fb_limit    <= FB_LIMIT_RST;
            cfg_reg.side_limit  <= SIDE_LIMIT_RST;
            cfg_reg.deadband    <= DEADBAND_RST;
            cfg_reg.apply_limit <= APPLY_RST;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000,
                            out_reg.ankle_roll_offset,
                            out_reg.hip_roll_offset,
                            out_reg.ankle_pitch_write,
                            out_reg.ankle_pitch_offset,
                            out_reg.knee_write,
                            out_reg.knee_offset};

endmodule

FILE: rtl/gbo_div.sv
module gbo_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gbo_pkg::DIV_W-1:0] dividend,
    input  logic [gbo_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic                      done,
    output logic [gbo_pkg::DIV_W-1:0] quotient
);
    import gbo_pkg::*;

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   step_hi;
    logic [DIV_W:0]   step_lo;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DIV_W-1:0] dvs);
        logic [DIV_W:0] t;
        logic [DIV_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, dvs};
        if (t >= d)
        begin
            div_step = {1'b1, DIV_W'(t - d)};
        end
        else
        begin
            div_step = {1'b0, t[DIV_W-1:0]};
        end
    endfunction

    // two quotient bits per cycle
    always_comb
    begin
        step_hi   = div_step(rem_reg, dvd_reg[DIV_W-1], dvs_reg);
        step_lo   = div_step(step_hi[DIV_W-1:0], dvd_reg[DIV_W-2], dvs_reg);
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-3:0], step_hi[DIV_W], step_lo[DIV_W]};
            rem_next = step_lo[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < CNT_W'(DIV_CYCLES)))
        else $error("divider step count out of range");

endmodule

FILE: rtl/gbo_core.sv
module gbo_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  gbo_pkg::item_t item,
    input  gbo_pkg::cfg_t  cfg,
    output logic           res_valid,
    input  logic           res_ready,
    output gbo_pkg::res_t  res
);
    import gbo_pkg::*;

    state_t                   state_reg, state_next;
    logic                     go_reg, go_next;
    item_t                    item_reg, item_next;
    logic [TIME_W-1:0]        last_reg, last_next;
    logic signed [ERR3_W-1:0] fb3_reg, fb3_next;
    logic signed [ERR3_W-1:0] sd3_reg, sd3_next;
    logic [DIV_W-1:0]         fb_mag_reg, fb_mag_next;
    logic [DIV_W-1:0]         sd_mag_reg, sd_mag_next;
    logic                     fb_neg_reg, fb_neg_next;
    logic                     sd_neg_reg, sd_neg_next;
    logic [DIV_W-1:0]         dmag_reg, dmag_next;
    logic [DIV_W-1:0]         emag_reg, emag_next;
    logic                     dneg_reg, dneg_next;
    logic                     eneg_reg, eneg_next;
    logic [KNEE_MAG_W-1:0]    knee_mag_reg, knee_mag_next;
    logic [ANKLE_MAG_W-1:0]   ankle_mag_reg, ankle_mag_next;
    logic [AROLL_MAG_W-1:0]   aroll_mag_reg, aroll_mag_next;
    logic [HROLL_MAG_W-1:0]   hroll_mag_reg, hroll_mag_next;

    logic [TIME_W-1:0]        elapsed;
    logic signed [DIFF_W-1:0] fb_diff;
    logic signed [DIFF_W-1:0] sd_diff;
    logic [DIV_W-2:0]         half_dev;
    logic [KNEE_MAG_W-1:0]    knee_prod;
    logic                     in_div;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dvd;
    logic [DIV_W-1:0]         div_dvs;
    logic                     div_busy;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quot;
    logic [KNEE_OUT_W-1:0]    knee_sat;
    logic [ANKLE_OUT_W-1:0]   ankle_ext;
    logic [HROLL_OUT_W-1:0]   hroll_ext;
    logic [AROLL_OUT_W-1:0]   aroll_ext;

    // clamp to +-lim and return the magnitude
    function automatic logic [DIV_W-1:0] clamp_mag(input logic signed [ERR3_W-1:0] v,
                                                   input logic [DIV_W-1:0]         lim);
        logic signed [ERR3_W-1:0] l;
        logic signed [ERR3_W-1:0] c;
        l = $signed({{(ERR3_W - DIV_W){1'b0}}, lim});
        if (v > l)
        begin
            c = l;
        end
        else if (v < -l)
        begin
            c = -l;
        end
        else
        begin
            c = v;
        end
        if (c[ERR3_W-1])
        begin
            c = -c;
        end
        clamp_mag = c[DIV_W-1:0];
    endfunction

    gbo_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        elapsed  = item_reg.time_ms - last_reg;
        fb_diff  = $signed({3'b000, item_reg.gyro_front_back})
                 - $signed({item_reg.wanted_front_back[WANT_W-1], item_reg.wanted_front_back});
        sd_diff  = $signed({3'b000, item_reg.gyro_side})
                 - $signed({item_reg.wanted_side[WANT_W-1], item_reg.wanted_side});
        half_dev = dmag_reg[DIV_W-1:1];
        knee_prod = KNEE_MAG_W'(knee_mag_reg[KNEE_Q_W-1:0]) * KNEE_MAG_W'(half_dev);

        state_next     = state_reg;
        go_next        = go_reg;
        item_next      = item_reg;
        last_next      = last_reg;
        fb3_next       = fb3_reg;
        sd3_next       = sd3_reg;
        fb_mag_next    = fb_mag_reg;
        sd_mag_next    = sd_mag_reg;
        fb_neg_next    = fb_neg_reg;
        sd_neg_next    = sd_neg_reg;
        dmag_next      = dmag_reg;
        emag_next      = emag_reg;
        dneg_next      = dneg_reg;
        eneg_next      = eneg_reg;
        knee_mag_next  = knee_mag_reg;
        ankle_mag_next = ankle_mag_reg;
        aroll_mag_next = aroll_mag_reg;
        hroll_mag_next = hroll_mag_reg;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        in_div         = 1'b0;
        div_start      = 1'b0;
        div_dvd        = fb_mag_reg;
        div_dvs        = KNEE_DIV;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (elapsed >= {{(TIME_W - CFG_DATA_W){1'b0}}, cfg.period})
                begin
                    last_next = item_reg.time_ms;
                    // times 3 as x + 2x
                    fb3_next  = $signed({{2{fb_diff[DIFF_W-1]}}, fb_diff})
                              + $signed({fb_diff[DIFF_W-1], fb_diff, 1'b0});
                    sd3_next  = $signed({{2{sd_diff[DIFF_W-1]}}, sd_diff})
                              + $signed({sd_diff[DIFF_W-1], sd_diff, 1'b0});
                    dneg_next = item_reg.knee_position < item_reg.knee_goal;
                    dmag_next = dneg_next ? item_reg.knee_goal - item_reg.knee_position
                                          : item_reg.knee_position - item_reg.knee_goal;
                    eneg_next = item_reg.ankle_position < item_reg.ankle_goal;
                    emag_next = eneg_next ? item_reg.ankle_goal - item_reg.ankle_position
                                          : item_reg.ankle_position - item_reg.ankle_goal;
                    state_next = S_CLAMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLAMP:
            begin
                fb_mag_next = clamp_mag(fb3_reg, cfg.fb_limit);
                sd_mag_next = clamp_mag(sd3_reg, cfg.side_limit);
                fb_neg_next = fb3_reg[ERR3_W-1];
                sd_neg_next = sd3_reg[ERR3_W-1];
                state_next  = S_DIV_KNEE;
            end
            S_DIV_KNEE:
            begin
                in_div  = 1'b1;
                div_dvd = fb_mag_reg;
                div_dvs = KNEE_DIV;
                if (div_done)
                begin
                    knee_mag_next = KNEE_MAG_W'(div_quot);
                    state_next    = S_DIV_ANKLE;
                end
            end
            S_DIV_ANKLE:
            begin
                in_div  = 1'b1;
                div_dvd = fb_mag_reg;
                div_dvs = ANKLE_DIV;
                if (div_done)
                begin
                    ankle_mag_next = div_quot[ANKLE_MAG_W-1:0];
                    state_next     = S_DIV_AROLL;
                end
            end
            S_DIV_AROLL:
            begin
                in_div  = 1'b1;
                div_dvd = sd_mag_reg;
                div_dvs = AROLL_DIV;
                if (div_done)
                begin
                    aroll_mag_next = div_quot[AROLL_MAG_W-1:0];
                    state_next     = S_DIV_HROLL;
                end
            end
            S_DIV_HROLL:
            begin
                in_div  = 1'b1;
                div_dvd = sd_mag_reg;
                div_dvs = HROLL_DIV;
                if (div_done)
                begin
                    hroll_mag_next = div_quot[HROLL_MAG_W-1:0];
                    state_next     = S_KNEE_ADJ;
                end
            end
            S_KNEE_ADJ:
            begin
                state_next = S_ANKLE_ADJ;
                if (dmag_reg > cfg.deadband && knee_mag_reg != '0)
                begin
                    if (dneg_reg == fb_neg_reg)
                    begin
                        // a zero half deviation leaves the knee term as is
                        if (half_dev != '0)
                        begin
                            state_next = S_KNEE_DIV;
                        end
                    end
                    else
                    begin
                        knee_mag_next = knee_prod;
                    end
                end
            end
            S_KNEE_DIV:
            begin
                in_div  = 1'b1;
                div_dvd = knee_mag_reg[DIV_W-1:0];
                div_dvs = {1'b0, half_dev};
                if (div_done)
                begin
                    knee_mag_next = KNEE_MAG_W'(div_quot);
                    state_next    = S_ANKLE_ADJ;
                end
            end
            S_ANKLE_ADJ:
            begin
                if (emag_reg > cfg.deadband && ankle_mag_reg != '0 && eneg_reg == fb_neg_reg)
                begin
                    state_next = S_ANKLE_DIV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_ANKLE_DIV:
            begin
                in_div  = 1'b1;
                div_dvd = DIV_W'(ankle_mag_reg);
                div_dvs = emag_reg;
                if (div_done)
                begin
                    ankle_mag_next = div_quot[ANKLE_MAG_W-1:0];
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch the divider once on entry, then wait for its result
        if (in_div)
        begin
            if (!go_reg)
            begin
                div_start = 1'b1;
                go_next   = 1'b1;
            end
            else if (div_done)
            begin
                go_next = 1'b0;
            end
        end
    end

    // result formatting with knee saturation
    always_comb
    begin
        if (fb_neg_reg)
        begin
            knee_sat = (knee_mag_reg > KNEE_MAG_W'(KNEE_NEG_MAX)) ? KNEE_NEG_MAX
                                                                 : knee_mag_reg[KNEE_OUT_W-1:0];
        end
        else
        begin
            knee_sat = (knee_mag_reg > KNEE_MAG_W'(KNEE_POS_MAX)) ? KNEE_POS_MAX
                                                                 : knee_mag_reg[KNEE_OUT_W-1:0];
        end
        ankle_ext = ANKLE_OUT_W'(ankle_mag_reg);
        hroll_ext = HROLL_OUT_W'(hroll_mag_reg);
        aroll_ext = AROLL_OUT_W'(aroll_mag_reg);

        res.knee_offset        = fb_neg_reg ? -knee_sat : knee_sat;
        res.knee_write         = knee_sat < KNEE_OUT_W'(cfg.apply_limit);
        res.ankle_pitch_offset = fb_neg_reg ? -ankle_ext : ankle_ext;
        res.ankle_pitch_write  = APPLY_W'(ankle_mag_reg) < cfg.apply_limit;
        res.hip_roll_offset    = sd_neg_reg ? -hroll_ext : hroll_ext;
        res.ankle_roll_offset  = sd_neg_reg ? -aroll_ext : aroll_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        fb3_reg       <= fb3_next;
        sd3_reg       <= sd3_next;
        fb_mag_reg    <= fb_mag_next;
        sd_mag_reg    <= sd_mag_next;
        fb_neg_reg    <= fb_neg_next;
        sd_neg_reg    <= sd_neg_next;
        dmag_reg      <= dmag_next;
        emag_reg      <= emag_next;
        dneg_reg      <= dneg_next;
        eneg_reg      <= eneg_next;
        knee_mag_reg  <= knee_mag_next;
        ankle_mag_reg <= ankle_mag_next;
        aroll_mag_reg <= aroll_mag_next;
        hroll_mag_reg <= hroll_mag_next;
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider launched while busy");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (go_reg && in_div))
        else $error("divider result with no division outstanding");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!div_busy && !go_reg))
        else $error("ready while a division is in flight");

endmodule

FILE: tb/sv/gyro_balance_offset_step_top_test.sv
`timescale 1ns / 100ps

module gyro_balance_offset_step_top_test;
    import gbo_pkg::*;

    localparam int HALF_PERIOD_NS = 4;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PCT       = 38;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the registers and the update time
    logic [CFG_DATA_W-1:0]  period_ms = PERIOD_RST;
    logic [CFG_DATA_W-1:0]  fb_limit = FB_LIMIT_RST;
    logic [CFG_DATA_W-1:0]  side_limit = SIDE_LIMIT_RST;
    logic [CFG_DATA_W-1:0]  deadband = DEADBAND_RST;
    logic [APPLY_W-1:0]     apply_limit = APPLY_RST;
    logic [TIME_W-1:0]      last_update_ms = '0;

    res_t                   offsets_due[$];
    logic [TIME_W-1:0]      stim_ms = '0;
    bit                     src_idle_on = 1'b1;
    bit                     sink_stall_on = 1'b1;
    int                     items_sent = 0;
    int                     updates_seen = 0;
    int                     cfg_writes = 0;
    int                     mismatches = 0;
    int                     watchdog_cnt = 0;

    gyro_balance_offset_step_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD_NS) clk = ~clk;

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_to(input int v, input int lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // returns 1 when the item triggers an update, with the offsets in r
    function automatic bit predict_offsets(input item_t it, output res_t r);
        logic [TIME_W-1:0] elapsed;
        int fb, sd, knee, ankle, d, e, h;
        r = '0;
        elapsed = it.time_ms - last_update_ms;
        if (elapsed < period_ms)
            return 1'b0;
        last_update_ms = it.time_ms;

        fb = clamp_to(3 * (int'(it.gyro_front_back) - int'(it.wanted_front_back)),
                      int'(fb_limit));
        sd = clamp_to(3 * (int'(it.gyro_side) - int'(it.wanted_side)), int'(side_limit));
        knee  = fb / 70;
        ankle = fb / 25;

        // knee strayed from goal: shrink when moving the same way, grow otherwise
        d = int'(it.knee_position) - int'(it.knee_goal);
        if (magnitude(d) > int'(deadband) && knee != 0)
        begin
            h = magnitude(d) / 2;
            if ((d < 0) == (knee < 0))
            begin
                if (h != 0)
                    knee = knee / h;
            end
            else
            begin
                knee = knee * h;
            end
        end
        if (knee > 2047)
            knee = 2047;
        if (knee < -2048)
            knee = -2048;

        e = int'(it.ankle_position) - int'(it.ankle_goal);
        if (magnitude(e) > int'(deadband) && ankle != 0 && (e < 0) == (ankle < 0))
            ankle = ankle / magnitude(e);

        r.knee_offset        = knee[KNEE_OUT_W-1:0];
        r.knee_write         = magnitude(knee) < int'(apply_limit);
        r.ankle_pitch_offset = ankle[ANKLE_OUT_W-1:0];
        r.ankle_pitch_write  = magnitude(ankle) < int'(apply_limit);
        r.hip_roll_offset    = HROLL_OUT_W'(sd / 52);
        r.ankle_roll_offset  = AROLL_OUT_W'(sd / 30);
        return 1'b1;
    endfunction

    task automatic send_item(input item_t it);
        res_t due;
        while (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= IN_TDATA_W'({it.ankle_goal, it.ankle_position, it.knee_goal,
                                      it.knee_position, it.wanted_side, it.wanted_front_back,
                                      it.gyro_side, it.gyro_front_back, it.time_ms});
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (predict_offsets(it, due))
            offsets_due.push_back(due);
    endtask

    task automatic send_pose(input int unsigned dt, input int gfb, input int wfb,
                             input int gsd, input int wsd, input int kp, input int kg,
                             input int ap, input int ag);
        item_t it;
        stim_ms += dt;
        it.time_ms           = stim_ms;
        it.gyro_front_back   = GYRO_W'(gfb);
        it.wanted_front_back = WANT_W'(wfb);
        it.gyro_side         = GYRO_W'(gsd);
        it.wanted_side       = WANT_W'(wsd);
        it.knee_position     = POS_W'(kp);
        it.knee_goal         = POS_W'(kg);
        it.ankle_position    = POS_W'(ap);
        it.ankle_goal        = POS_W'(ag);
        send_item(it);
    endtask

    // mostly small errors and deviations so the deviation paths get exercised
    task automatic send_random();
        int unsigned dt;
        int gfb, gsd, wfb, wsd, kg, kp, ag, ap;
        dt = 0;
        case ($urandom_range(19))
            0: stim_ms = $urandom;
            1: dt = (period_ms > 0) ? $urandom_range(period_ms - 1) : 0;
            default: dt = $urandom_range(2 * period_ms + 2);
        endcase
        gfb = $urandom_range(1023);
        gsd = $urandom_range(1023);
        if ($urandom_range(3) == 0)
        begin
            wfb = $urandom;
            wsd = $urandom;
        end
        else
        begin
            wfb = gfb + int'($urandom_range(400)) - 200;
            wsd = gsd + int'($urandom_range(400)) - 200;
        end
        kg = $urandom_range(1023);
        ag = $urandom_range(1023);
        kp = ($urandom_range(3) == 0) ? $urandom_range(1023) : kg + int'($urandom_range(80)) - 40;
        ap = ($urandom_range(3) == 0) ? $urandom_range(1023) : ag + int'($urandom_range(80)) - 40;
        send_pose(dt, gfb, wfb, gsd, wsd, kp, kg, ap, ag);
    endtask

    task automatic drain_offsets();
        s_axis_tvalid <= 1'b0;
        while (offsets_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_writes++;
        case (idx)
            REG_PERIOD:      period_ms = CFG_DATA_W'(value);
            REG_FB_LIMIT:    fb_limit = CFG_DATA_W'(value);
            REG_SIDE_LIMIT:  side_limit = CFG_DATA_W'(value);
            REG_DEADBAND:    deadband = CFG_DATA_W'(value);
            REG_APPLY_LIMIT: apply_limit = APPLY_W'(CFG_DATA_W'(value));
            default: ;
        endcase
    endtask

    task automatic set_config(input int per, input int fbl, input int sdl, input int db,
                              input int apl);
        drain_offsets();
        write_reg(REG_PERIOD, per);
        write_reg(REG_FB_LIMIT, fbl);
        write_reg(REG_SIDE_LIMIT, sdl);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_APPLY_LIMIT, apl);
        cfg_valid <= 1'b0;
    endtask

    // reset registers, early times inside the first period, field extremes
    task automatic test_power_on_defaults();
        send_pose(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(29, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(30, 1023, 2047, 1023, 2047, 1023, 1023, 1023, 1023);
        send_pose(30, 1023, -2048, 1023, -2048, 0, 1023, 1023, 0);
        send_pose(30, 0, 2047, 0, 2047, 1023, 0, 0, 1023);
        send_pose(30, 512, 512, 300, 300, 512, 512, 512, 512);
    endtask

    task automatic test_deviation_paths();
        set_config(1, 1023, 1023, 0, 100);
        // half deviation rounds to zero, knee term left alone
        send_pose(1, 600, 0, 600, 0, 501, 500, 600, 500);
        // opposite signs multiply and saturate both ways
        send_pose(1, 600, 0, 0, 600, 0, 1023, 495, 500);
        send_pose(1, 0, 600, 600, 0, 1023, 0, 497, 500);
        send_pose(1, 600, 0, 300, 0, 600, 500, 400, 500);
        set_config(1, 250, 300, 1023, 1);
        send_pose(1, 1023, -2048, 0, 2047, 0, 1023, 1023, 0);
        send_pose(1, 500, 500, 500, 500, 0, 1023, 0, 1023);
        // deviation exactly on the deadband is not enough
        set_config(1, 500, 500, 40, 5);
        send_pose(1, 400, 200, 400, 200, 540, 500, 540, 500);
        send_pose(1, 400, 200, 400, 200, 541, 500, 541, 500);
    endtask

    task automatic test_update_timing();
        set_config(1000, 250, 300, 15, 5);
        send_pose(1000, 700, 300, 200, 600, 300, 320, 300, 280);
        send_pose(999, 700, 300, 200, 600, 300, 320, 300, 280);
        send_pose(1, 700, 300, 200, 600, 300, 320, 300, 280);
        // time counter wraps past zero
        stim_ms = 32'hFFFF_FE00;
        send_pose(0, 100, 400, 900, 100, 10, 900, 900, 10);
        send_pose(1000, 100, 400, 900, 100, 10, 900, 900, 10);
        // zero period updates on every item, even with the same time
        set_config(0, 250, 300, 15, 5);
        send_pose(0, 800, 100, 100, 800, 200, 100, 100, 200);
        send_pose(0, 100, 800, 800, 100, 100, 200, 200, 100);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_config(PERIOD_RST, FB_LIMIT_RST, SIDE_LIMIT_RST, DEADBAND_RST, APPLY_RST);
                1: set_config(0, 1023, 1023, 0, 127);
                2: set_config(1000, 0, 0, 1023, 1);
                3: set_config(1, 1000, 1000, 0, 100);
                default: set_config($urandom_range(1023), $urandom_range(1023),
                                    $urandom_range(1023),
                                    $urandom_range(1) ? $urandom_range(60) : $urandom_range(1023),
                                    $urandom_range(1023));
            endcase
            // first phase runs back to back on both sides
            src_idle_on   = (phase != 0);
            sink_stall_on = (phase != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(49) == 0)
                    drain_offsets();
                send_random();
            end
        end
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    always @(posedge clk)
        m_axis_tready <= sink_stall_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    always @(posedge clk)
    begin : offset_check
        res_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.knee_offset        = m_axis_tdata[11:0];
            got.knee_write         = m_axis_tdata[12];
            got.ankle_pitch_offset = m_axis_tdata[20:13];
            got.ankle_pitch_write  = m_axis_tdata[21];
            got.hip_roll_offset    = m_axis_tdata[27:22];
            got.ankle_roll_offset  = m_axis_tdata[34:28];
            if (offsets_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected offset transaction tdata=%h", m_axis_tdata);
            end
            else
            begin
                want = offsets_due.pop_front();
                updates_seen++;
                if (got !== want || m_axis_tdata[OUT_TDATA_W-1:35] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"offset mismatch at update %0d: knee %0d/%0d w %b/%b ",
                                  "pitch %0d/%0d w %b/%b hip %0d/%0d roll %0d/%0d pad %h ",
                                  "(expected/actual)"},
                                 updates_seen, want.knee_offset, got.knee_offset,
                                 want.knee_write, got.knee_write, want.ankle_pitch_offset,
                                 got.ankle_pitch_offset, want.ankle_pitch_write,
                                 got.ankle_pitch_write, want.hip_roll_offset,
                                 got.hip_roll_offset, want.ankle_roll_offset,
                                 got.ankle_roll_offset, m_axis_tdata[OUT_TDATA_W-1:35]);
                end
            end
        end
    end

    // cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            watchdog_cnt <= 0;
        else if (watchdog_cnt >= WATCHDOG_LIMIT)
        begin
            $display("stalled for %0d cycles with %0d offsets outstanding",
                     watchdog_cnt, offsets_due.size());
            $display("gyro_balance_offset_step_top test failed");
            $finish;
        end
        else
            watchdog_cnt <= watchdog_cnt + 1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on_defaults();
        test_deviation_paths();
        test_update_timing();
        test_random_traffic();
        drain_offsets();
        $display("sent %0d pose items, checked %0d balance updates, %0d register writes",
                 items_sent, updates_seen, cfg_writes);
        $display("covered update timing, time wrap, clamps, deadband and saturation paths");
        if (mismatches == 0)
            $display("gyro_balance_offset_step_top test passed");
        else
            $display("gyro_balance_offset_step_top test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/gbo_pkg.sv
rtl/gbo_div.sv
rtl/gbo_core.sv
rtl/gyro_balance_offset_step_top.sv
tb/sv/gyro_balance_offset_step_top_test.sv
